@@ rtl/tfhe_pkg.sv @@
// shared types, codes and expansion tables for the html escape filter
package tfhe_pkg;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] REG_FILTER_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NBSP        = 2'd1;

    // filter modes
    localparam logic [2:0] MODE_NONE   = 3'd0;
    localparam logic [2:0] MODE_UPPER  = 3'd1;
    localparam logic [2:0] MODE_LOWER  = 3'd2;
    localparam logic [2:0] MODE_NOHIGH = 3'd3;
    localparam logic [2:0] MODE_NOSPC  = 3'd4;
    localparam logic [2:0] MODE_HTML   = 3'd5;

    // characters
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_SEMI  = 8'h3b;
    localparam logic [7:0] CH_LT    = 8'h3c;
    localparam logic [7:0] CH_GT    = 8'h3e;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_A_UC  = 8'h41;
    localparam logic [7:0] CH_Z_UC  = 8'h5a;
    localparam logic [7:0] CH_A_LC  = 8'h61;
    localparam logic [7:0] CH_Z_LC  = 8'h7a;
    localparam logic [7:0] CH_L     = 8'h6c;
    localparam logic [7:0] CH_G     = 8'h67;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_M     = 8'h6d;
    localparam logic [7:0] CH_P     = 8'h70;
    localparam logic [7:0] CH_N     = 8'h6e;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_S     = 8'h73;
    localparam logic [7:0] HIGH_LIMIT = 8'd127;
    localparam logic [7:0] CASE_DIFF  = 8'd32;

    // kind of expansion the back end has to produce
    typedef enum logic [2:0] {
        K_CHAR,
        K_LT,
        K_GT,
        K_AMP,
        K_NBSP,
        K_NUM
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] ch;
        logic [1:0] hund;
        logic [3:0] tens;
        logic [3:0] ones;
    } t_token;

    // number of output beats for a token
    function automatic logic [2:0] tfhe_len(t_kind kind);
        logic [2:0] len;
        unique case (kind)
            K_CHAR:  len = 3'd1;
            K_LT:    len = 3'd4;
            K_GT:    len = 3'd4;
            K_AMP:   len = 3'd5;
            K_NBSP:  len = 3'd6;
            K_NUM:   len = 3'd6;
            default: len = 3'd1;
        endcase
        return len;
    endfunction

    // output byte at position idx of a token's expansion
    function automatic logic [7:0] tfhe_tok_byte(t_token tok, logic [2:0] idx);
        logic [7:0] b;
        b = CH_AMP;
        unique case (tok.kind)
            K_CHAR: b = tok.ch;
            K_LT, K_GT: begin
                case (idx)
                    3'd0:    b = CH_AMP;
                    3'd1:    b = (tok.kind == K_LT) ? CH_L : CH_G;
                    3'd2:    b = CH_T;
                    default: b = CH_SEMI;
                endcase
            end
            K_AMP: begin
                case (idx)
                    3'd0:    b = CH_AMP;
                    3'd1:    b = CH_A_LC;
                    3'd2:    b = CH_M;
                    3'd3:    b = CH_P;
                    default: b = CH_SEMI;
                endcase
            end
            K_NBSP: begin
                case (idx)
                    3'd0:    b = CH_AMP;
                    3'd1:    b = CH_N;
                    3'd2:    b = CH_B;
                    3'd3:    b = CH_S;
                    3'd4:    b = CH_P;
                    default: b = CH_SEMI;
                endcase
            end
            K_NUM: begin
                case (idx)
                    3'd0:    b = CH_AMP;
                    3'd1:    b = CH_HASH;
                    3'd2:    b = CH_ZERO + {6'd0, tok.hund};
                    3'd3:    b = CH_ZERO + {4'd0, tok.tens};
                    3'd4:    b = CH_ZERO + {4'd0, tok.ones};
                    default: b = CH_SEMI;
                endcase
            end
            default: b = tok.ch;
        endcase
        return b;
    endfunction

endpackage

@@ rtl/tfhe_front.sv @@
// front end: config registers and per-byte classification into tokens
module tfhe_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    input  logic [tfhe_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [tfhe_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_in_valid,
    input  logic [7:0]                     i_in_byte,
    input  logic                           i_full,
    output logic                           o_push,
    output tfhe_pkg::t_token               o_tok
);
    import tfhe_pkg::*;

    logic [2:0]  r_mode;
    logic        r_nbsp;
    logic        keep;
    t_token      tok;
    logic [1:0]  hund;
    logic [6:0]  rem;
    logic [14:0] prod;
    logic [3:0]  tens;
    logic [7:0]  tens_x10;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_NONE;
            r_nbsp <= 1'b0;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == REG_FILTER_MODE) begin
                r_mode <= i_cfg_data[2:0];
            end else if (i_cfg_index == REG_NBSP) begin
                r_nbsp <= i_cfg_data[0];
            end
        end
    end

    // decimal digits for bytes 127..255: hundreds by compare, tens by reciprocal
    always_comb begin
        hund     = (i_in_byte >= 8'd200) ? 2'd2 : 2'd1;
        rem      = (i_in_byte >= 8'd200) ? 7'(i_in_byte - 8'd200) : 7'(i_in_byte - 8'd100);
        prod     = 15'(rem) * 15'd205;
        tens     = prod[14:11];
        tens_x10 = 8'(tens) * 8'd10;
    end

    always_comb begin
        keep     = 1'b1;
        tok.kind = K_CHAR;
        tok.ch   = i_in_byte;
        tok.hund = hund;
        tok.tens = tens;
        tok.ones = 4'(8'(rem) - tens_x10);
        unique case (r_mode)
            MODE_UPPER: begin
                if (i_in_byte >= CH_A_LC && i_in_byte <= CH_Z_LC) begin
                    tok.ch = i_in_byte - CASE_DIFF;
                end
            end
            MODE_LOWER: begin
                if (i_in_byte >= CH_A_UC && i_in_byte <= CH_Z_UC) begin
                    tok.ch = i_in_byte + CASE_DIFF;
                end
            end
            MODE_NOHIGH: keep = (i_in_byte < HIGH_LIMIT);
            MODE_NOSPC:  keep = (i_in_byte != CH_SPACE);
            MODE_HTML: begin
                if (i_in_byte == CH_LT) begin
                    tok.kind = K_LT;
                end else if (i_in_byte == CH_GT) begin
                    tok.kind = K_GT;
                end else if (i_in_byte == CH_AMP) begin
                    tok.kind = K_AMP;
                end else if (i_in_byte == CH_SPACE && r_nbsp) begin
                    tok.kind = K_NBSP;
                end else if (i_in_byte >= HIGH_LIMIT) begin
                    tok.kind = K_NUM;
                end
            end
            default: keep = 1'b1;
        endcase
    end

    assign o_push = i_in_valid && !i_full && keep;
    assign o_tok  = tok;

endmodule

@@ rtl/tfhe_fifo.sv @@
// short token queue between front and back end
module tfhe_fifo #(
    parameter int unsigned DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  tfhe_pkg::t_token i_wr_data,
    input  logic             i_pop,
    output tfhe_pkg::t_token o_rd_data,
    output logic             o_empty,
    output logic             o_full
);
    import tfhe_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    t_token           r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] n_rd_ptr;

    always_comb begin
        n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_rd_data = r_mem[r_rd_ptr];
    assign o_empty   = (r_count == '0);
    assign o_full    = (r_count == CNT_W'(DEPTH));

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0 || r_count == CNT_W'(DEPTH)) |-> r_wr_ptr == r_rd_ptr)
        else $error("queue pointers disagree with count");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into full queue");

endmodule

@@ rtl/tfhe_back.sv @@
// back end: expands tokens into output bytes through an output register
module tfhe_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  tfhe_pkg::t_token i_tok,
    input  logic             i_empty,
    output logic             o_pop,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic [7:0]       o_out_byte,
    output logic             o_last_byte
);
    import tfhe_pkg::*;

    t_token     r_tok;
    logic       r_busy;
    logic [2:0] r_idx;
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_out_last;
    logic       adv;
    logic       is_last;
    logic       load;

    always_comb begin
        adv     = r_busy && (!r_out_valid || !i_out_stall);
        is_last = (r_idx == tfhe_len(r_tok.kind) - 3'd1);
        load    = !i_empty && (!r_busy || (adv && is_last));
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_tok <= i_tok;
        end
        if (adv) begin
            r_out_byte <= tfhe_tok_byte(r_tok, r_idx);
            r_out_last <= is_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
            end else if (adv && is_last) begin
                r_busy <= 1'b0;
            end else if (adv) begin
                r_idx <= r_idx + 3'd1;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_pop       = load;
    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_last_byte = r_out_last;

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_idx < tfhe_len(r_tok.kind))
        else $error("expansion index past token length");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> !i_empty)
        else $error("pop from empty queue");

    a_mid_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && !is_last) |=> r_busy && !r_out_last)
        else $error("token ended before its last byte");

endmodule

@@ rtl/text_filter_html_escape_core.sv @@
// top level of the byte filter with html entity escaping
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+------------------------------
//  in      | sink      | i_in_valid / o_in_stall | i_in_byte
//  out     | source    | o_out_valid / i_out_stall | o_out_byte, o_last_byte
//  cfg     | sink      | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
//  one output beat per cycle while tokens are queued and i_out_stall is low; an input
//  byte expands to 0 to 6 output bytes (1 for plain bytes, 4 for &lt; &gt;, 5 for &amp;,
//  6 for &nbsp; and &#ddd;); the back end expansion counter sets the rate; the front
//  takes a byte per cycle while the token queue has room
//  reset is synchronous, active low, and empties queue and output register
//  o_in_stall follows queue full only; i_out_stall holds the output register and the expansion
module text_filter_html_escape_core #(
    parameter int unsigned DEPTH = 4
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration write channel
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [tfhe_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [tfhe_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // input byte channel
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [7:0]                      i_in_byte,
    // output byte channel
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [7:0]                      o_out_byte,
    output logic                            o_last_byte
);
    import tfhe_pkg::*;

    // token handoff between the two halves
    t_token push_tok;
    t_token pop_tok;
    logic   push;
    logic   pop;
    logic   empty;
    logic   full;

    // register writes are always taken; the user writes them only while idle (unchecked)
    assign o_cfg_ready = 1'b1;

    // stall the producer only when the queue has no room
    assign o_in_stall = full;

    // classification: dropped bytes never reach the queue
    tfhe_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .i_in_byte   (i_in_byte),
        .i_full      (full),
        .o_push      (push),
        .o_tok       (push_tok)
    );

    // decouples input acceptance from multi-beat expansion
    tfhe_fifo #(
        .DEPTH (DEPTH)
    ) u_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_wr_data (push_tok),
        .i_pop     (pop),
        .o_rd_data (pop_tok),
        .o_empty   (empty),
        .o_full    (full)
    );

    // expansion sequencer with registered output beat
    tfhe_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tok       (pop_tok),
        .i_empty     (empty),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_byte  (o_out_byte),
        .o_last_byte (o_last_byte)
    );

endmodule
